### rtl/core/tcce_pkg.sv
// Shared constants and types for the text console cursor engine.
// No dependencies; used by the engine top level.
`default_nettype none

package tcce_pkg;

  // Default screen geometry
  localparam int ROWS_DEF    = 25;
  localparam int COLUMNS_DEF = 80;

  // Field widths fixed by the interface
  localparam int CMD_W  = 2;
  localparam int CHR_W  = 8;
  localparam int AMT_W  = 12;
  localparam int ADDR_W = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Signed width for cursor arithmetic before normalization
  localparam int NRM_W = 14;

  localparam logic [CHR_W-1:0]  CHR_NEWLINE   = 8'h0A;
  localparam logic [CHR_W-1:0]  CHR_BACKSPACE = 8'h08;
  localparam logic [CHR_W-1:0]  CHR_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK   = {ATTR_RESET, CHR_SPACE};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/tcce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/text_console_cursor_engine_core.sv
// Text console cursor engine: cell buffer in one RAM plus cursor and sweep sequencer.
// Depends on tcce_pkg and tcce_ram.
//
//   channel | signals                                         | dir | beat moves
//   in      | in_valid/in_ready, command, char, amount, axis, | in  | one command
//           | cell_address                                    |     |
//   out     | out_valid/out_ready, cursor_location, cell_value| out | one result
//   cfg     | cfg_valid/cfg_ready, cfg_text_attribute         | in  | attribute byte
//
// Put, newline and move return to idle through S_DONE unless they scroll or shift;
// read passes through S_RD first. Scroll copies one cell per cycle through the RAM's
// single read and write port, and backspace and clear sweep the cells too. After reset
// a clearing pass over every cell runs with in_ready low; cfg is always ready. A held
// result stalls only the next result.
`default_nettype none

module text_console_cursor_engine_core #(
  parameter int ROWS    = tcce_pkg::ROWS_DEF,
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [tcce_pkg::CMD_W-1:0]        in_command,
  input  wire logic [tcce_pkg::CHR_W-1:0]        in_char_code,
  input  wire logic signed [tcce_pkg::AMT_W-1:0] in_move_amount,
  input  wire logic                              in_move_axis,
  input  wire logic [tcce_pkg::ADDR_W-1:0]       in_cell_address,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [tcce_pkg::LOC_W-1:0]        out_cursor_location,
  output      logic [tcce_pkg::CELL_W-1:0]       out_cell_value,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [tcce_pkg::ATTR_W-1:0]       cfg_text_attribute
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CB    = $clog2(COLUMNS);
  localparam int RB    = $clog2(ROWS);
  localparam int CW    = ((AW > tcce_pkg::ADDR_W) ? AW : tcce_pkg::ADDR_W) + 1;
  localparam int NW    = tcce_pkg::NRM_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_COPY,
    S_FILL,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [CB-1:0]                 col_r;
  logic [RB-1:0]                 row_r;
  logic [tcce_pkg::ATTR_W-1:0]   attr_r;
  logic [PW-1:0]                 rd_ptr_r;
  logic [AW-1:0]                 wr_ptr_r;
  logic                          cp_vld_r;
  logic                          in_rng_r;
  logic [tcce_pkg::CELL_W-1:0]   cell_r;
  logic                          out_valid_r;
  logic [tcce_pkg::LOC_W-1:0]    out_loc_r;
  logic [tcce_pkg::CELL_W-1:0]   out_cell_r;

  logic                          accept;
  logic [AW-1:0]                 pos;
  logic [tcce_pkg::LOC_W-1:0]    loc;
  logic [tcce_pkg::CELL_W-1:0]   blank;
  logic                          is_nl;
  logic                          is_bs;
  logic                          cp_rd;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [tcce_pkg::CELL_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [tcce_pkg::CELL_W-1:0]   mem_rdata;

  logic signed [NW-1:0]          nc_in;
  logic signed [NW-1:0]          nr_in;
  logic [CB-1:0]                 norm_col;
  logic [RB-1:0]                 norm_row;
  logic                          norm_scroll;

  assign accept              = in_valid && in_ready;
  assign in_ready            = (state_r == S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_cursor_location = out_loc_r;
  assign out_cell_value      = out_cell_r;

  assign pos   = AW'(int'(row_r) * COLUMNS + int'(col_r));
  assign loc   = tcce_pkg::LOC_W'(int'(row_r) * COLUMNS + int'(col_r));
  assign blank = {attr_r, tcce_pkg::CHR_SPACE};
  assign is_nl = (in_char_code == tcce_pkg::CHR_NEWLINE);
  assign is_bs = (in_char_code == tcce_pkg::CHR_BACKSPACE);
  assign cp_rd = (rd_ptr_r != PW'(CELLS));

  // Raw cursor step for the accepted command
  always_comb begin
    nc_in = NW'($signed({1'b0, col_r}));
    nr_in = NW'($signed({1'b0, row_r}));
    case (in_command)
      tcce_pkg::CMD_PUT: begin
        if (is_nl) begin
          nc_in = '0;
          nr_in = nr_in + NW'(1);
        end else if (is_bs) begin
          if (pos != '0) begin
            nc_in = nc_in - NW'(1);
          end
        end else begin
          nc_in = nc_in + NW'(1);
        end
      end
      tcce_pkg::CMD_MOVE: begin
        if (in_move_axis) begin
          nc_in = nc_in + NW'(in_move_amount);
        end else begin
          nr_in = nr_in + NW'(in_move_amount);
        end
      end
      default: begin
      end
    endcase
  end

  // Wrap the column, clamp at the origin, scroll once past the bottom
  always_comb begin
    logic signed [NW-1:0] c;
    logic signed [NW-1:0] r;
    c = nc_in;
    r = nr_in;
    if (c < 0) begin
      if (r > 0) begin
        c = NW'(COLUMNS - 1);
        r = r - NW'(1);
      end else begin
        c = '0;
      end
    end
    if (r < 0) begin
      r = '0;
    end
    if (c > NW'(COLUMNS - 1)) begin
      c = '0;
      r = r + NW'(1);
    end
    norm_scroll = (r >= NW'(ROWS));
    if (norm_scroll) begin
      r = NW'(ROWS - 1);
    end
    norm_col = CB'(c);
    norm_row = RB'(r);
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_r;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = AW'(rd_ptr_r);
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcce_pkg::RESET_BLANK;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            tcce_pkg::CMD_PUT: begin
              if (is_bs) begin
                mem_we    = (pos != '0);
                mem_waddr = pos - AW'(1);
              end else if (!is_nl) begin
                mem_we    = 1'b1;
                mem_waddr = pos;
                mem_wdata = {attr_r, in_char_code};
              end
            end
            tcce_pkg::CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(in_cell_address);
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        mem_re    = cp_rd;
        mem_we    = cp_vld_r;
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcce_pkg::ATTR_RESET;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cp_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
      // completion reloads the result register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          wr_ptr_r <= wr_ptr_r + AW'(1);
          if (wr_ptr_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cell_r <= '0;
            case (in_command)
              tcce_pkg::CMD_PUT, tcce_pkg::CMD_MOVE: begin
                col_r    <= norm_col;
                row_r    <= norm_row;
                cp_vld_r <= 1'b0;
                if (in_command == tcce_pkg::CMD_PUT && is_bs && pos != '0) begin
                  // shift everything after the cursor left by one
                  rd_ptr_r <= PW'(pos) + PW'(1);
                  wr_ptr_r <= pos;
                  state_r  <= S_COPY;
                end else if (norm_scroll) begin
                  rd_ptr_r <= PW'(COLUMNS);
                  wr_ptr_r <= '0;
                  state_r  <= S_COPY;
                end else begin
                  state_r <= S_DONE;
                end
              end
              tcce_pkg::CMD_CLEAR: begin
                col_r    <= '0;
                row_r    <= '0;
                wr_ptr_r <= '0;
                state_r  <= S_FILL;
              end
              default: begin
                in_rng_r <= (CW'(in_cell_address) < CW'(CELLS));
                state_r  <= S_RD;
              end
            endcase
          end
        end
        S_RD: begin
          cell_r  <= in_rng_r ? mem_rdata : '0;
          state_r <= S_DONE;
        end
        S_COPY: begin
          // read runs one cell ahead of the write-back
          cp_vld_r <= cp_rd;
          if (cp_rd) begin
            rd_ptr_r <= rd_ptr_r + PW'(1);
          end
          if (cp_vld_r) begin
            wr_ptr_r <= wr_ptr_r + AW'(1);
          end
          if (!cp_rd && !cp_vld_r) begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          wr_ptr_r <= wr_ptr_r + AW'(1);
          if (wr_ptr_r == AW'(CELLS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_loc_r   <= loc;
            out_cell_r  <= cell_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_range : assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_copy_order : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr < mem_raddr))
    else $error("copy write overtook its read");

  a_idle_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !accept) |-> !mem_we)
    else $error("cell write while idle");

  a_read_path : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == tcce_pkg::CMD_READ) |=> (state_r == S_RD))
    else $error("read command skipped the read cycle");

  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside completion");

endmodule

`default_nettype wire
